>>> src/lpg_pkg.sv
// Package for the LFSR LED pattern generator.
// Holds widths, reset values, register indexes and the config struct.
// No dependencies.
`timescale 1ns / 1ps

package lpg_pkg;

  localparam int unsigned LEDS_PER_SIDE = 48;
  localparam int unsigned LfsrW         = 32;
  localparam int unsigned ColorW        = 24;
  localparam int unsigned ChanW         = 8;
  localparam int unsigned StepsW        = 8;
  localparam int unsigned LedIdxW       = 6;
  localparam int unsigned PaddrW        = 4;
  localparam int unsigned PdataW        = 32;

  localparam logic [LfsrW-1:0]   TAP_MASK_RST  = 32'h0000_6000;
  localparam logic [ColorW-1:0]  LED_COLOR_RST = 24'hff00ff;
  localparam logic               RGB_MODE_RST  = 1'b0;
  localparam logic [LfsrW-1:0]   LFSR_SEED     = 32'h0000_0001;

  localparam int unsigned BIT_RED   = 20;
  localparam int unsigned BIT_GREEN = 21;
  localparam int unsigned BIT_BLUE  = 22;
  localparam logic [ChanW-1:0] FULL_ON = 8'hff;

  localparam logic [LedIdxW-1:0] LED_FIRST = LedIdxW'(LEDS_PER_SIDE - 1);

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_TAP_MASK  = 2'd0;
  localparam logic [1:0] REG_LED_COLOR = 2'd1;
  localparam logic [1:0] REG_RGB_MODE  = 2'd2;

  typedef struct packed {
    logic [LfsrW-1:0]  tap_mask;
    logic [ColorW-1:0] led_color;
    logic              rgb_mode;
  } cfg_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

endpackage

>>> src/lpg_regs.sv
// APB-style configuration registers of the LED pattern generator.
// Depends on lpg_pkg.
`timescale 1ns / 1ps

module lpg_regs import lpg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tap_mask  <= TAP_MASK_RST;
      cfg_q.led_color <= LED_COLOR_RST;
      cfg_q.rgb_mode  <= RGB_MODE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TAP_MASK:  cfg_q.tap_mask  <= pwdata;
        REG_LED_COLOR: cfg_q.led_color <= pwdata[ColorW-1:0];
        REG_RGB_MODE:  cfg_q.rgb_mode  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TAP_MASK:  prdata = cfg_q.tap_mask;
      REG_LED_COLOR: prdata = {{(PdataW-ColorW){1'b0}}, cfg_q.led_color};
      REG_RGB_MODE:  prdata = {{(PdataW-1){1'b0}}, cfg_q.rgb_mode};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/lpg_lfsr_step.sv
// Shared LFSR advance unit: one shift with parity feedback.
// Depends on lpg_pkg.
`timescale 1ns / 1ps

module lpg_lfsr_step import lpg_pkg::*; (
  input  logic [LfsrW-1:0] state_i,
  input  logic [LfsrW-1:0] tap_mask_i,
  output logic [LfsrW-1:0] next_o
);

  logic fb;

  assign fb     = ^(state_i & tap_mask_i);
  assign next_o = {state_i[LfsrW-2:0], fb};

endmodule

>>> src/lpg_color.sv
// Maps the working LFSR word to one LED color (single or RGB mode).
// Depends on lpg_pkg.
`timescale 1ns / 1ps

module lpg_color import lpg_pkg::*; (
  input  logic [LfsrW-1:0] work_i,
  input  cfg_t             cfg_i,
  output rgb_t             color_o
);

  logic on;

  assign on = work_i[0];

  always_comb begin
    color_o = '0;
    if (on) begin
      if (cfg_i.rgb_mode) begin
        color_o.red   = work_i[BIT_RED]   ? FULL_ON : '0;
        color_o.green = work_i[BIT_GREEN] ? FULL_ON : '0;
        color_o.blue  = work_i[BIT_BLUE]  ? FULL_ON : '0;
      end else begin
        color_o.red   = cfg_i.led_color[23:16];
        color_o.green = cfg_i.led_color[15:8];
        color_o.blue  = cfg_i.led_color[7:0];
      end
    end
  end

endmodule

>>> src/lfsr_led_pattern_generator.sv
// Top level of the LFSR LED pattern generator: sequencer, stored and
// working LFSR words, output register. Uses lpg_pkg, lpg_regs,
// lpg_lfsr_step and lpg_color.
//
//  channel  | handshake                    | word
//  ---------+------------------------------+-----------------------------------
//  input    | in_valid_i / in_ready_o      | advance_steps_i, restart_i
//  output   | out_valid_o / out_ready_i    | led_index_o, red/green/blue_o,
//           |                              | last_led_o
//  config   | psel, penable, pwrite/pready | paddr, pwdata, prdata
//
// A request steps the stored word advance_steps times, copies it to the
// working word, then steps the working copy once per LED: the single LFSR
// step unit serves first the stored word, then the working copy per LED.
// Output stalls hold the render sequence; in_ready_o is high only when idle.
// Reset loads the stored word with 1 and the config registers to defaults.
`timescale 1ns / 1ps

module lfsr_led_pattern_generator import lpg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [StepsW-1:0]  advance_steps_i,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [LedIdxW-1:0] led_index_o,
  output logic [ChanW-1:0]   red_o,
  output logic [ChanW-1:0]   green_o,
  output logic [ChanW-1:0]   blue_o,
  output logic               last_led_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PaddrW-1:0]  paddr,
  input  logic [PdataW-1:0]  pwdata,
  output logic [PdataW-1:0]  prdata,
  output logic               pready
);

  localparam logic [1:0] StIdle    = 2'd0;
  localparam logic [1:0] StAdvance = 2'd1;
  localparam logic [1:0] StRender  = 2'd2;

  cfg_t cfg;

  logic [1:0]         state_q, state_d;
  logic [LfsrW-1:0]   lfsr_q, lfsr_d;
  logic [LfsrW-1:0]   work_q, work_d;
  logic [StepsW-1:0]  steps_q, steps_d;
  logic [LedIdxW-1:0] idx_q, idx_d;

  logic               out_valid_q, out_valid_d;
  logic [LedIdxW-1:0] out_idx_q, out_idx_d;
  rgb_t               out_rgb_q, out_rgb_d;
  logic               out_last_q, out_last_d;

  logic [LfsrW-1:0]   step_in, step_out;
  rgb_t               color;
  logic               slot_free;

  lpg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // one step unit, shared between stored word and working copy
  assign step_in = (state_q == StRender) ? work_q : lfsr_q;

  lpg_lfsr_step u_step (
    .state_i    (step_in),
    .tap_mask_i (cfg.tap_mask),
    .next_o     (step_out)
  );

  lpg_color u_color (
    .work_i  (work_q),
    .cfg_i   (cfg),
    .color_o (color)
  );

  assign in_ready_o = (state_q == StIdle);
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    lfsr_d      = lfsr_q;
    work_d      = work_q;
    steps_d     = steps_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_idx_d   = out_idx_q;
    out_rgb_d   = out_rgb_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (restart_i) lfsr_d = LFSR_SEED;
          steps_d = advance_steps_i;
          state_d = StAdvance;
        end
      end
      StAdvance: begin
        if (steps_q == '0) begin
          work_d  = lfsr_q;
          idx_d   = LED_FIRST;
          state_d = StRender;
        end else begin
          lfsr_d  = step_out;
          steps_d = steps_q - 1'b1;
        end
      end
      StRender: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = idx_q;
          out_rgb_d   = color;
          out_last_d  = (idx_q == '0);
          work_d      = step_out;
          idx_d       = idx_q - 1'b1;
          if (idx_q == '0) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      lfsr_q      <= LFSR_SEED;
      steps_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lfsr_q      <= lfsr_d;
      steps_q     <= steps_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q     <= work_d;
    out_idx_q  <= out_idx_d;
    out_rgb_q  <= out_rgb_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign led_index_o = out_idx_q;
  assign red_o       = out_rgb_q.red;
  assign green_o     = out_rgb_q.green;
  assign blue_o      = out_rgb_q.blue;
  assign last_led_o  = out_last_q;

endmodule
